// ===== sv/assert_macros.svh =====
// Assertion macros used by the allocator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an implication holds on every clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check an implication in the cycle after the antecedent
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/ffha_pkg.sv =====
// Types and constants of the first-fit heap allocator
package ffha_pkg;
  localparam int unsigned BASE_W = 47;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned SIZE_W = 32;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;
  localparam logic [1:0] ST_NULL    = 2'd3;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [0:0] CFG_BASE  = 1'd0;
  localparam logic [0:0] CFG_BYTES = 1'd1;

  // One table entry
  typedef struct packed {
    logic [SIZE_W-1:0] offset;
    logic [SIZE_W-1:0] size;
    logic              free;
  } seg_t;
endpackage

// ===== sv/first_fit_heap_allocator.sv =====
// Top level: first-fit heap allocator with coalescing over a segment memory
//
// channel | ports                                       | handshake
// in      | in_action, in_request_bytes, in_address     | start & !busy
// out     | out_granted_address, out_status, out_free_  | done, one cycle
//         | bytes, out_total_bytes                      |
// cfg     | cfg_we, cfg_index, cfg_data                 | cfg_we
//
// An allocate scans entries one per cycle through the memory's read port, then
// moves the tail up one entry at a time (read, write) when it splits. A free
// scans the same way, then moves the tail down one entry at a time (read, write)
// for each merge. A configuration write rebuilds the table as one free segment
// with a single write, or as an empty heap when the size is below a header;
// reset leaves an empty heap. busy also covers the done cycle.
// The receiver cannot stall.
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned HEADER_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_action,
  input  logic [SIZE_W-1:0]   in_request_bytes,
  input  logic [ADDR_W-1:0]   in_address,
  output logic                done,
  output logic [ADDR_W-1:0]   out_granted_address,
  output logic [1:0]          out_status,
  output logic [SIZE_W-1:0]   out_free_bytes,
  output logic [SIZE_W-1:0]   out_total_bytes,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [BASE_W-1:0]   cfg_data
);
`include "assert_macros.svh"

  localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [SIZE_W-1:0] HDR = SIZE_W'(HEADER_BYTES);
  localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;  // read issued for idx
  localparam logic [3:0] S_EVAL  = 4'd2;  // data of idx present
  localparam logic [3:0] S_UPRD  = 4'd3;  // split: read k-1
  localparam logic [3:0] S_UPWR  = 4'd4;  // split: write k
  localparam logic [3:0] S_NXRD  = 4'd5;  // free: read neighbor
  localparam logic [3:0] S_NXEV  = 4'd6;
  localparam logic [3:0] S_DNRD  = 4'd7;  // remove: read k+1
  localparam logic [3:0] S_DNWR  = 4'd8;  // remove: write k
  localparam logic [3:0] S_PVEV  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;
  localparam logic [3:0] S_CUR   = 4'd11; // free: read predecessor

  logic [3:0]        state_r, state_nxt;
  logic [BASE_W-1:0] hbase_r, hbase_nxt;
  logic [SIZE_W-1:0] hbytes_r, hbytes_nxt;
  logic [BASE_W-1:0] abase_r, abase_nxt;
  logic [SIZE_W-1:0] asize_r, asize_nxt;
  logic [SIZE_W-1:0] fcnt_r, fcnt_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic              act_r, act_nxt;
  logic [SIZE_W:0]   need_r, need_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [1:0]        st_r, st_nxt;
  logic [ADDR_W-1:0] gr_r, gr_nxt;
  seg_t              cur_r, cur_nxt;     // entry being freed (merged)
  seg_t              ins_r, ins_nxt;     // entry to insert after split
  logic              mprev_r, mprev_nxt; // merge with predecessor pending
  logic              done_r, done_nxt;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  seg_t              wdata, rdata;

  ffha_seg_ram #(.DEPTH(MAX_SEGMENTS), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Rebuild values from the configured registers
  logic [BASE_W-1:0] cb;
  logic [SIZE_W-1:0] cs;
  logic [3:0]        adj;
  logic [BASE_W-1:0] rb_base;
  logic [SIZE_W-1:0] rb_size, rb_tmp;

  always_comb begin
    cb = hbase_nxt;
    cs = hbytes_nxt;
    adj = 4'(5'd16 - {1'b0, cb[3:0]});
    rb_base = cb + BASE_W'(adj);
    rb_tmp = (cs >= SIZE_W'(adj)) ? cs - SIZE_W'(adj) : '0;
    rb_size = {rb_tmp[SIZE_W-1:4], 4'h0};
  end

  logic [ADDR_W-1:0] rd_addr;
  assign rd_addr = ADDR_W'({1'b0, abase_r} + {16'h0, rdata.offset} + {16'h0, HDR});

  // Neighbor indexes of the scan and shift pointers
  logic [CW-1:0] idx_p1, idx_m1, k_p1, k_m1;
  assign idx_p1 = idx_r + 1'b1;
  assign idx_m1 = idx_r - 1'b1;
  assign k_p1 = k_r + 1'b1;
  assign k_m1 = k_r - 1'b1;

  logic rebuild;
  logic [SIZE_W:0] need_c;
  assign need_c = ({1'b0, in_request_bytes} + (SIZE_W+1)'(15)) & ~(SIZE_W+1)'(15);

  always_comb begin
    state_nxt = state_r;
    hbase_nxt = hbase_r;
    hbytes_nxt = hbytes_r;
    abase_nxt = abase_r;
    asize_nxt = asize_r;
    fcnt_nxt = fcnt_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    k_nxt = k_r;
    act_nxt = act_r;
    need_nxt = need_r;
    addr_nxt = addr_r;
    st_nxt = st_r;
    gr_nxt = gr_r;
    cur_nxt = cur_r;
    ins_nxt = ins_r;
    mprev_nxt = mprev_r;
    done_nxt = 1'b0;
    we = 1'b0;
    waddr = idx_r[AW-1:0];
    wdata = rdata;
    raddr = idx_r[AW-1:0];
    rebuild = 1'b0;

    if (cfg_we) begin
      rebuild = 1'b1;
      if (cfg_index == CFG_BASE) begin
        hbase_nxt = cfg_data;
      end else begin
        hbytes_nxt = cfg_data[SIZE_W-1:0];
      end
    end

    case (state_r)
      S_IDLE: begin
        // hold off while the previous word is still on the result ports
        if (start && !done_r) begin
          act_nxt = in_action;
          need_nxt = need_c;
          addr_nxt = in_address;
          idx_nxt = '0;
          gr_nxt = '0;
          mprev_nxt = 1'b0;
          if (in_action == ACT_FREE && in_address == '0) begin
            st_nxt = ST_NULL;
            state_nxt = S_DONE;
          end else begin
            st_nxt = (in_action == ACT_FREE) ? ST_BAD : ST_NO_FIT;
            state_nxt = (cnt_r == '0) ? S_DONE : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (act_r == ACT_ALLOC) begin
          if (rdata.free && {1'b0, rdata.size} >= need_r) begin
            st_nxt = ST_OK;
            gr_nxt = rd_addr;
            we = 1'b1;
            wdata.free = 1'b0;
            if ({1'b0, rdata.size} > need_r + (SIZE_W+1)'(HDR) + (SIZE_W+1)'(16)
                && cnt_r < MAXC) begin
              wdata.size = need_r[SIZE_W-1:0];
              ins_nxt.offset = rdata.offset + HDR + need_r[SIZE_W-1:0];
              ins_nxt.size = rdata.size - need_r[SIZE_W-1:0] - HDR;
              ins_nxt.free = 1'b1;
              fcnt_nxt = fcnt_r - need_r[SIZE_W-1:0] - HDR;
              k_nxt = cnt_r;
              cnt_nxt = cnt_r + 1'b1;
              state_nxt = S_UPRD;
            end else begin
              fcnt_nxt = fcnt_r - rdata.size - HDR;
              state_nxt = S_DONE;
            end
          end else if (idx_r + 1'b1 >= cnt_r) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_p1;
            raddr = idx_p1[AW-1:0];
            state_nxt = S_EVAL;
          end
        end else begin
          if (!rdata.free && rd_addr == addr_r) begin
            st_nxt = ST_OK;
            cur_nxt = rdata;
            cur_nxt.free = 1'b1;
            fcnt_nxt = fcnt_r + rdata.size + HDR;
            we = 1'b1;
            wdata.free = 1'b1;
            state_nxt = S_NXRD;
          end else if (idx_r + 1'b1 >= cnt_r) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_p1;
            raddr = idx_p1[AW-1:0];
            state_nxt = S_EVAL;
          end
        end
      end
      // Split: move entries idx+1..cnt-2 up by one, then insert
      S_UPRD: begin
        if (k_r == idx_r + 1'b1) begin
          we = 1'b1;
          waddr = k_r[AW-1:0];
          wdata = ins_r;
          state_nxt = S_DONE;
        end else begin
          raddr = k_m1[AW-1:0];
          state_nxt = S_UPWR;
        end
      end
      S_UPWR: begin
        we = 1'b1;
        waddr = k_r[AW-1:0];
        wdata = rdata;
        k_nxt = k_r - 1'b1;
        state_nxt = S_UPRD;
      end
      // Free: look at the successor
      S_NXRD: begin
        if (idx_r + 1'b1 < cnt_r) begin
          raddr = idx_p1[AW-1:0];
          state_nxt = S_NXEV;
        end else begin
          mprev_nxt = 1'b1;
          state_nxt = S_CUR;
        end
      end
      S_NXEV: begin
        mprev_nxt = 1'b1;
        if (rdata.free) begin
          cur_nxt.size = cur_r.size + rdata.size + HDR;
          we = 1'b1;
          wdata = cur_r;
          wdata.size = cur_r.size + rdata.size + HDR;
          k_nxt = idx_r + 1'b1;
          state_nxt = S_DNRD;
        end else begin
          state_nxt = S_CUR;
        end
      end
      // Remove entry k: pull k+1.. down one place
      S_DNRD: begin
        if (k_r + 1'b1 >= cnt_r) begin
          cnt_nxt = cnt_r - 1'b1;
          state_nxt = mprev_r ? S_CUR : S_DONE;
          mprev_nxt = 1'b0;
          if (!mprev_r) begin
            state_nxt = S_DONE;
          end
        end else begin
          raddr = k_p1[AW-1:0];
          state_nxt = S_DNWR;
        end
      end
      S_DNWR: begin
        we = 1'b1;
        waddr = k_r[AW-1:0];
        wdata = rdata;
        k_nxt = k_r + 1'b1;
        state_nxt = S_DNRD;
      end
      // Free: look at the predecessor
      S_CUR: begin
        mprev_nxt = 1'b0;
        if (idx_r != '0) begin
          raddr = idx_m1[AW-1:0];
          state_nxt = S_PVEV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PVEV: begin
        if (rdata.free) begin
          we = 1'b1;
          waddr = idx_m1[AW-1:0];
          wdata = rdata;
          wdata.size = rdata.size + cur_r.size + HDR;
          k_nxt = idx_r;
          state_nxt = S_DNRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        done_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (rebuild) begin
      abase_nxt = rb_base;
      asize_nxt = rb_size;
      fcnt_nxt = rb_size;
      we = 1'b1;
      waddr = '0;
      wdata.offset = '0;
      wdata.size = rb_size - HDR;
      wdata.free = 1'b1;
      cnt_nxt = (rb_size >= HDR) ? CW'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hbase_r <= '0;
      hbytes_r <= '0;
      abase_r <= '0;
      asize_r <= '0;
      fcnt_r <= '0;
      cnt_r <= '0;
      done_r <= 1'b0;
      mprev_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hbase_r <= hbase_nxt;
      hbytes_r <= hbytes_nxt;
      abase_r <= abase_nxt;
      asize_r <= asize_nxt;
      fcnt_r <= fcnt_nxt;
      cnt_r <= cnt_nxt;
      done_r <= done_nxt;
      mprev_r <= mprev_nxt;
    end
    idx_r <= idx_nxt;
    k_r <= k_nxt;
    act_r <= act_nxt;
    need_r <= need_nxt;
    addr_r <= addr_nxt;
    st_r <= st_nxt;
    gr_r <= gr_nxt;
    cur_r <= cur_nxt;
    ins_r <= ins_nxt;
  end

  assign busy = (state_r != S_IDLE) || done_r;
  assign done = done_r;
  assign out_granted_address = gr_r;
  assign out_status = st_r;
  assign out_free_bytes = fcnt_r;
  assign out_total_bytes = asize_r;

  `ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= MAXC, "segment count over depth")
  `ASSERT_NXT(a_done_pulse, clk, rst_n, done_r, !done_r, "done longer than one cycle")
  `ASSERT_IMP(a_grant_ok, clk, rst_n, done_r && gr_r != '0, st_r == ST_OK, "grant with error")
endmodule

// ===== sv/ffha_seg_ram.sv =====
// Segment table memory: one write port, one registered read port
module ffha_seg_ram import ffha_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  seg_t          wdata,
  input  logic [AW-1:0] raddr,
  output seg_t          rdata
);
  seg_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== test/first_fit_heap_allocator_tb.sv =====
// Self-checking testbench for the first-fit heap allocator: directed table, then random traffic
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam int unsigned SEGS = 64;
  localparam int unsigned HDR = 32;
  localparam int unsigned LIMIT = 3000000;

  typedef struct packed {
    logic [ADDR_W-1:0] granted;
    logic [1:0]        status;
    logic [SIZE_W-1:0] free_bytes;
    logic [SIZE_W-1:0] total_bytes;
  } grant_t;

  typedef struct packed {
    logic              action;
    logic [SIZE_W-1:0] request_bytes;
    logic [ADDR_W-1:0] address;
    logic              typed;
    logic [1:0]        want_status;
    logic [ADDR_W-1:0] want_granted;
  } row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_action;
  logic [SIZE_W-1:0]   in_request_bytes;
  logic [ADDR_W-1:0]   in_address;
  logic                done;
  logic [ADDR_W-1:0]   out_granted_address;
  logic [1:0]          out_status;
  logic [SIZE_W-1:0]   out_free_bytes;
  logic [SIZE_W-1:0]   out_total_bytes;
  logic                cfg_we;
  logic [0:0]          cfg_index;
  logic [BASE_W-1:0]   cfg_data;

  first_fit_heap_allocator #(.MAX_SEGMENTS(SEGS), .HEADER_BYTES(HDR)) dut (.*);

  // heap model
  logic [BASE_W-1:0] reg_base;
  logic [SIZE_W-1:0] reg_bytes;
  logic [BASE_W-1:0] base_al;
  logic [SIZE_W-1:0] size_al;
  logic [SIZE_W-1:0] free_now;
  logic [SIZE_W-1:0] seg_off [SEGS];
  logic [SIZE_W-1:0] seg_size [SEGS];
  logic              seg_free [SEGS];
  int unsigned       seg_count;

  grant_t            pending[$];
  logic [ADDR_W-1:0] live[$];
  logic [ADDR_W-1:0] last_freed;
  int unsigned       mismatches, cycles, n_items, n_grants, n_nofit, n_frees, n_bad, n_null, n_cfg;
  int unsigned       burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending.size());
      $display("first_fit_heap_allocator regression: fail");
      $finish;
    end
  end

  function automatic void rebuild_heap();
    logic [63:0] b, s, adj;
    b = {17'b0, reg_base};
    s = {32'b0, reg_bytes};
    adj = (64'd16 - (b & 64'd15)) & 64'd15;
    b = (b + adj) & 64'h7FFF_FFFF_FFFF;
    s = (s >= adj) ? s - adj : 64'd0;
    s = s & ~64'd15;
    base_al = b[BASE_W-1:0];
    size_al = s[SIZE_W-1:0];
    free_now = size_al;
    for (int i = 0; i < SEGS; i++) begin
      seg_off[i] = '0;
      seg_size[i] = '0;
      seg_free[i] = 1'b0;
    end
    if (size_al >= HDR) begin
      seg_size[0] = size_al - HDR;
      seg_free[0] = 1'b1;
      seg_count = 1;
    end else begin
      seg_count = 0;
    end
  endfunction

  function automatic logic [ADDR_W-1:0] data_addr(int unsigned i);
    logic [63:0] a;
    a = {17'b0, base_al} + {32'b0, seg_off[i]} + HDR;
    return a[ADDR_W-1:0];
  endfunction

  function automatic void drop_entry(int unsigned i);
    for (int unsigned k = i; k + 1 < seg_count; k++) begin
      seg_off[k] = seg_off[k+1];
      seg_size[k] = seg_size[k+1];
      seg_free[k] = seg_free[k+1];
    end
    seg_count--;
  endfunction

  // Apply one request to the heap model and return its result word
  function automatic grant_t serve_request(logic act, logic [SIZE_W-1:0] req,
                                           logic [ADDR_W-1:0] addr);
    grant_t r;
    logic [63:0] need, sz;
    bit hit;
    r = '0;
    hit = 0;
    if (act == ACT_ALLOC) begin
      need = ({32'b0, req} + 64'd15) & ~64'd15;
      r.status = ST_NO_FIT;
      for (int unsigned i = 0; i < seg_count && !hit; i++) begin
        if (seg_free[i] && {32'b0, seg_size[i]} >= need) begin
          sz = {32'b0, seg_size[i]};
          if (sz > need + HDR + 16 && seg_count < SEGS) begin
            for (int unsigned k = seg_count; k > i + 1; k--) begin
              seg_off[k] = seg_off[k-1];
              seg_size[k] = seg_size[k-1];
              seg_free[k] = seg_free[k-1];
            end
            seg_off[i+1] = seg_off[i] + HDR + need[SIZE_W-1:0];
            seg_size[i+1] = sz[SIZE_W-1:0] - need[SIZE_W-1:0] - HDR;
            seg_free[i+1] = 1'b1;
            seg_size[i] = need[SIZE_W-1:0];
            seg_count++;
          end
          seg_free[i] = 1'b0;
          free_now = free_now - seg_size[i] - HDR;
          r.granted = data_addr(i);
          r.status = ST_OK;
          hit = 1;
        end
      end
    end else if (addr == '0) begin
      r.status = ST_NULL;
    end else begin
      r.status = ST_BAD;
      for (int unsigned i = 0; i < seg_count && !hit; i++) begin
        if (!seg_free[i] && data_addr(i) == addr) begin
          seg_free[i] = 1'b1;
          free_now = free_now + seg_size[i] + HDR;
          if (i + 1 < seg_count && seg_free[i+1]) begin
            seg_size[i] = seg_size[i] + seg_size[i+1] + HDR;
            drop_entry(i + 1);
          end
          if (i > 0 && seg_free[i-1]) begin
            seg_size[i-1] = seg_size[i-1] + seg_size[i] + HDR;
            drop_entry(i);
          end
          r.status = ST_OK;
          hit = 1;
        end
      end
    end
    r.free_bytes = free_now;
    r.total_bytes = size_al;
    return r;
  endfunction

  // Compare every result word with the oldest expectation
  always @(posedge clk) begin
    grant_t want, got;
    if (rst_n && done) begin
      got = {out_granted_address, out_status, out_free_bytes, out_total_bytes};
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", got);
      end else begin
        want = pending.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: addr %h/%h status %0d/%0d free %h/%h total %h/%h (exp/act)",
                     want.granted, got.granted, want.status, got.status,
                     want.free_bytes, got.free_bytes, want.total_bytes, got.total_bytes);
        end
      end
    end
  end

  // Hold the word on the ports until accepted, then record its expectation
  task automatic send_word(logic act, logic [SIZE_W-1:0] req, logic [ADDR_W-1:0] addr,
                           bit typed = 0, logic [1:0] st = ST_OK,
                           logic [ADDR_W-1:0] ga = '0);
    grant_t r;
    start <= 1'b1;
    in_action <= act;
    in_request_bytes <= req;
    in_address <= addr;
    do @(posedge clk); while (busy);
    r = serve_request(act, req, addr);
    if (typed) begin
      r.status = st;
      r.granted = ga;
    end
    pending.push_back(r);
    n_items++;
    if (r.status == ST_OK && act == ACT_ALLOC) begin
      n_grants++;
      live.push_back(r.granted);
    end
    if (r.status == ST_OK && act == ACT_FREE) n_frees++;
    if (r.status == ST_NO_FIT) n_nofit++;
    if (r.status == ST_BAD) n_bad++;
    if (r.status == ST_NULL) n_null++;
    // burst / gap shaping
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [BASE_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BASE) reg_base = val;
    else reg_bytes = val[SIZE_W-1:0];
    rebuild_heap();
    live.delete();
    n_cfg++;
  endtask

  task automatic random_phase(logic [BASE_W-1:0] b, logic [SIZE_W-1:0] sz, int unsigned n,
                              int unsigned alloc_pct, int unsigned max_req);
    int unsigned sel, j;
    logic [ADDR_W-1:0] a;
    write_reg(CFG_BASE, b);
    write_reg(CFG_BYTES, {15'b0, sz});
    for (int unsigned it = 0; it < n; it++) begin
      if (it == n / 2) drain();
      sel = $urandom_range(0, 99);
      if (sel < alloc_pct) begin
        if ($urandom_range(0, 19) == 0) send_word(ACT_ALLOC, $urandom, '0);
        else send_word(ACT_ALLOC, $urandom_range(0, max_req), ADDR_W'({$urandom, $urandom}));
      end else if (sel < 95 && live.size() != 0) begin
        j = $urandom_range(0, live.size() - 1);
        a = live[j];
        live.delete(j);
        last_freed = a;
        send_word(ACT_FREE, $urandom, a);
      end else begin
        case ($urandom_range(0, 2))
          0: send_word(ACT_FREE, $urandom, '0);
          1: send_word(ACT_FREE, $urandom, last_freed);
          default: send_word(ACT_FREE, $urandom, ADDR_W'({$urandom, $urandom}));
        endcase
      end
    end
  endtask

  row_t early_rows[4];
  row_t late_rows[12];

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_action = ACT_ALLOC;
    in_request_bytes = '0;
    in_address = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_BASE;
    cfg_data = '0;
    reg_base = '0;
    reg_bytes = '0;
    last_freed = '0;
    burst_left = 0;
    {n_items, n_grants, n_nofit, n_frees, n_bad, n_null, n_cfg} = '0;
    rebuild_heap();

    // empty heap out of reset
    early_rows = '{
      '{ACT_ALLOC, 32'd0,          48'h0,            1'b1, ST_NO_FIT, 48'h0},
      '{ACT_ALLOC, 32'hFFFF_FFFF,  48'hFFFF_FFFF_FFFF, 1'b1, ST_NO_FIT, 48'h0},
      '{ACT_FREE,  32'hFFFF_FFFF,  48'h0,            1'b1, ST_NULL,   48'h0},
      '{ACT_FREE,  32'd0,          48'hFFFF_FFFF_FFFF, 1'b1, ST_BAD,    48'h0}
    };
    // 4 KiB heap at 0x1000
    late_rows = '{
      '{ACT_ALLOC, 32'd0,          48'h0,            1'b1, ST_OK,     48'h1020},
      '{ACT_ALLOC, 32'd16,         48'h0,            1'b1, ST_OK,     48'h1040},
      '{ACT_ALLOC, 32'd17,         48'h0,            1'b1, ST_OK,     48'h1070},
      '{ACT_ALLOC, 32'hFFFF_FFFF,  48'h0,            1'b1, ST_NO_FIT, 48'h0},
      '{ACT_FREE,  32'd0,          48'h1040,         1'b0, ST_OK,     48'h0},
      '{ACT_FREE,  32'd0,          48'h1040,         1'b1, ST_BAD,    48'h0},
      '{ACT_FREE,  32'd0,          48'h1041,         1'b1, ST_BAD,    48'h0},
      '{ACT_FREE,  32'd0,          48'h0,            1'b1, ST_NULL,   48'h0},
      '{ACT_FREE,  32'd0,          48'h1020,         1'b0, ST_OK,     48'h0},
      '{ACT_FREE,  32'd0,          48'h1070,         1'b0, ST_OK,     48'h0},
      '{ACT_ALLOC, 32'd4032,       48'h0,            1'b0, ST_OK,     48'h0},
      '{ACT_ALLOC, 32'd1,          48'h0,            1'b1, ST_NO_FIT, 48'h0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (early_rows[i])
      send_word(early_rows[i].action, early_rows[i].request_bytes, early_rows[i].address,
                early_rows[i].typed, early_rows[i].want_status, early_rows[i].want_granted);
    write_reg(CFG_BASE, 47'h1000);
    write_reg(CFG_BYTES, 47'h1000);
    foreach (late_rows[i])
      send_word(late_rows[i].action, late_rows[i].request_bytes, late_rows[i].address,
                late_rows[i].typed, late_rows[i].want_status, late_rows[i].want_granted);

    random_phase('0, 32'd0, 60, 60, 64);                         // no heap at all
    random_phase(47'h7FFF_FFFF_FFFF, 32'hFFFF_FFFF, 150, 60, 1 << 20); // base wraps, max size
    random_phase(47'd1, 32'd5, 60, 60, 64);                      // size below shift
    random_phase(47'd3, 32'd40, 60, 60, 64);                     // smaller than a header
    random_phase(BASE_W'({$urandom, $urandom}), 32'd4096, 350, 55, 256);
    random_phase(BASE_W'({$urandom, $urandom}), 32'd8192, 400, 80, 40);   // fill the table
    random_phase(BASE_W'({$urandom, $urandom}), 32'h8000, 350, 55, 2048);
    random_phase(47'h10, $urandom, 350, 60, 1 << 16);
    drain();
    repeat (200) @(posedge clk);

    $display("%0d requests over %0d register writes: %0d grants, %0d no-fit, %0d frees",
             n_items, n_cfg, n_grants, n_nofit, n_frees);
    $display("%0d bad frees, %0d null frees, %0d mismatches", n_bad, n_null, mismatches);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("first_fit_heap_allocator regression: pass");
    end else begin
      $display("first_fit_heap_allocator regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/ffha_pkg.sv
sv/ffha_seg_ram.sv
sv/first_fit_heap_allocator.sv
test/first_fit_heap_allocator_tb.sv
